// File: hdl/cdh_pkg.sv
package cdh_pkg;

    localparam int ACTION_W = 2;
    localparam int SPAN_W   = 10;
    localparam int BIN_W    = 10;
    localparam int DEPTH_W  = 24;
    localparam int COUNT_W  = 48;
    localparam int STATUS_W = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int RING_DEPTH_DEF = 1024;
    localparam int HIST_BINS_DEF  = 1024;

    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD     = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_NEWREF  = 2'd2,
        ACT_READBIN = 2'd3
    } t_action;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FILTERED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SPAN_LONG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        t_action               action;
        logic [STATUS_W-1:0]   pre_status;
        logic                  bin_in_range;
        logic [SPAN_W-1:0]     read_span;
        logic [BIN_W-1:0]      bin_index;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } t_back_stat;

endpackage

// File: hdl/cdh_in_if.sv
interface cdh_in_if;
    import cdh_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SPAN_W-1:0]   read_span;
    logic                is_mapped;
    logic                is_duplicate;
    logic                failed_qc;
    logic [BIN_W-1:0]    bin_index;

    modport source (
        output valid, action, read_span, is_mapped, is_duplicate, failed_qc, bin_index,
        input  ready
    );
    modport sink (
        input  valid, action, read_span, is_mapped, is_duplicate, failed_qc, bin_index,
        output ready
    );
endinterface

// File: hdl/cdh_out_if.sv
interface cdh_out_if;
    import cdh_pkg::*;

    logic                valid;
    logic                ready;
    logic [DEPTH_W-1:0]  current_depth;
    logic [COUNT_W-1:0]  bin_count;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, current_depth, bin_count, status,
        input  ready
    );
    modport sink (
        input  valid, current_depth, bin_count, status,
        output ready
    );
endinterface

// File: hdl/cdh_front.sv
module cdh_front #(
    parameter int RING_DEPTH = cdh_pkg::RING_DEPTH_DEF,
    parameter int HIST_BINS  = cdh_pkg::HIST_BINS_DEF
) (
    cdh_in_if.sink            i_in,
    input  cdh_pkg::t_back_stat i_stat,
    input  logic              i_queue_full,
    output logic              o_push,
    output cdh_pkg::t_cmd     o_cmd
);
    import cdh_pkg::*;

    logic w_filtered;
    logic w_span_long;

    assign w_filtered  = !i_in.is_mapped || i_in.is_duplicate || i_in.failed_qc;
    assign w_span_long = 32'(i_in.read_span) >= 32'(RING_DEPTH);

    // Nothing is taken while the memories are being cleared after reset.
    assign i_in.ready = !i_queue_full && !i_stat.init_busy;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_cmd.action       = t_action'(i_in.action);
        o_cmd.read_span    = i_in.read_span;
        o_cmd.bin_index    = i_in.bin_index;
        o_cmd.bin_in_range = 32'(i_in.bin_index) < 32'(HIST_BINS);
        o_cmd.pre_status   = ST_OK;
        if (t_action'(i_in.action) == ACT_ADD) begin
            priority if (w_filtered) begin
                o_cmd.pre_status = ST_FILTERED;
            end else if (w_span_long) begin
                o_cmd.pre_status = ST_SPAN_LONG;
            end else begin
                o_cmd.pre_status = ST_OK;
            end
        end
    end
endmodule

// File: hdl/cdh_queue.sv
module cdh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cdh_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cdh_pkg::t_cmd o_cmd
);
    import cdh_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr, n_wr;
    logic [QW-1:0] r_rd, n_rd;
    logic [QW:0]   r_count, n_count;

    assign o_full  = r_count == (QW+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count + (QW+1)'(i_push) - (QW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end
endmodule

// File: hdl/cdh_back.sv
module cdh_back #(
    parameter int RING_DEPTH = cdh_pkg::RING_DEPTH_DEF,
    parameter int HIST_BINS  = cdh_pkg::HIST_BINS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdh_pkg::t_cmd       i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    output cdh_pkg::t_back_stat o_stat,
    cdh_out_if.source           o_out
);
    import cdh_pkg::*;

    localparam int RW   = $clog2(RING_DEPTH);
    localparam int HW   = $clog2(HIST_BINS);
    localparam int MAXD = (RING_DEPTH > HIST_BINS) ? RING_DEPTH : HIST_BINS;
    localparam int MW   = $clog2(MAXD);
    localparam logic [RW:0]   RING_L    = (RW+1)'(RING_DEPTH);
    localparam logic [HW-1:0] LAST_BIN  = HW'(HIST_BINS - 1);
    localparam logic [RW-1:0] LAST_SLOT = RW'(RING_DEPTH - 1);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_HIST = 6'b001000,
        S_CLR  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [RW-1:0]        r_offset, n_offset;
    logic [RW-1:0]        r_slot, n_slot;
    logic [HW-1:0]        r_bin, n_bin;
    logic [MW-1:0]        r_clr_idx, n_clr_idx;
    logic [DEPTH_W-1:0]   r_res_depth, n_res_depth;
    logic [COUNT_W-1:0]   r_res_bin, n_res_bin;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic                 r_out_valid, n_out_valid;
    logic [DEPTH_W-1:0]   r_out_depth, n_out_depth;
    logic [COUNT_W-1:0]   r_out_bin, n_out_bin;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;

    logic [DEPTH_W-1:0]   r_ring [RING_DEPTH];
    logic [DEPTH_W-1:0]   r_ring_q;
    logic [COUNT_W-1:0]   r_hist [HIST_BINS];
    logic [COUNT_W-1:0]   r_hist_q;

    logic                 ring_we, ring_re;
    logic [RW-1:0]        ring_waddr, ring_raddr;
    logic [DEPTH_W-1:0]   ring_wdata;
    logic                 hist_we, hist_re;
    logic [HW-1:0]        hist_waddr, hist_raddr;
    logic [COUNT_W-1:0]   hist_wdata;

    logic [RW:0]          w_sum;
    logic [RW-1:0]        w_head_slot;
    logic [DEPTH_W-1:0]   w_close_depth;
    logic [HW-1:0]        w_close_bin;
    logic [COUNT_W-1:0]   w_hist_inc;
    logic                 w_out_free;

    // End slot of a read: offset plus span, folded once into the ring.
    assign w_sum       = {1'b0, r_offset} + {1'b0, RW'(i_cmd.read_span)};
    assign w_head_slot = (w_sum >= RING_L) ? RW'(w_sum - RING_L) : w_sum[RW-1:0];

    assign w_close_depth = (r_ring_q > r_depth) ? '0 : r_depth - r_ring_q;
    assign w_close_bin   = (32'(w_close_depth) >= 32'(HIST_BINS - 1)) ?
                           LAST_BIN : HW'(w_close_depth);
    assign w_hist_inc    = (r_hist_q == COUNT_MAX) ? r_hist_q : r_hist_q + 1'b1;
    assign w_out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_depth      = r_depth;
        n_offset     = r_offset;
        n_slot       = r_slot;
        n_bin        = r_bin;
        n_clr_idx    = r_clr_idx;
        n_res_depth  = r_res_depth;
        n_res_bin    = r_res_bin;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_depth  = r_out_depth;
        n_out_bin    = r_out_bin;
        n_out_status = r_out_status;
        o_cmd_pop    = 1'b0;
        ring_we      = 1'b0;
        ring_waddr   = r_offset;
        ring_wdata   = '0;
        ring_re      = 1'b0;
        ring_raddr   = r_offset;
        hist_we      = 1'b0;
        hist_waddr   = r_bin;
        hist_wdata   = '0;
        hist_re      = 1'b0;
        hist_raddr   = r_bin;

        unique case (r_state)
            S_INIT: begin
                ring_we    = 32'(r_clr_idx) < 32'(RING_DEPTH);
                ring_waddr = r_clr_idx[RW-1:0];
                hist_we    = 32'(r_clr_idx) < 32'(HIST_BINS);
                hist_waddr = r_clr_idx[HW-1:0];
                if (r_clr_idx == MW'(MAXD - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_cmd        = i_cmd;
                    n_res_bin    = '0;
                    n_res_status = i_cmd.pre_status;
                    n_res_depth  = r_depth;
                    unique case (i_cmd.action)
                        ACT_ADD: begin
                            priority if (i_cmd.pre_status != ST_OK) begin
                                n_state = S_OUT;
                            end else if (r_depth == DEPTH_MAX) begin
                                n_res_status = ST_SATURATED;
                                n_state      = S_OUT;
                            end else begin
                                ring_re    = 1'b1;
                                ring_raddr = w_head_slot;
                                n_slot     = w_head_slot;
                                n_state    = S_RD;
                            end
                        end
                        ACT_CLOSE: begin
                            ring_re    = 1'b1;
                            ring_raddr = r_offset;
                            n_state    = S_RD;
                        end
                        ACT_NEWREF: begin
                            n_clr_idx   = '0;
                            n_depth     = '0;
                            n_offset    = '0;
                            n_res_depth = '0;
                            n_state     = S_CLR;
                        end
                        ACT_READBIN: begin
                            if (i_cmd.bin_in_range) begin
                                hist_re    = 1'b1;
                                hist_raddr = HW'(i_cmd.bin_index);
                                n_state    = S_HIST;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_RD: begin
                if (r_cmd.action == ACT_ADD) begin
                    ring_we     = 1'b1;
                    ring_waddr  = r_slot;
                    ring_wdata  = r_ring_q + 1'b1;
                    n_depth     = r_depth + 1'b1;
                    n_res_depth = r_depth + 1'b1;
                    n_state     = S_OUT;
                end else begin
                    ring_we     = 1'b1;
                    ring_waddr  = r_offset;
                    ring_wdata  = '0;
                    n_depth     = w_close_depth;
                    n_res_depth = w_close_depth;
                    n_offset    = (r_offset == LAST_SLOT) ? '0 : r_offset + 1'b1;
                    hist_re     = 1'b1;
                    hist_raddr  = w_close_bin;
                    n_bin       = w_close_bin;
                    n_state     = S_HIST;
                end
            end
            S_HIST: begin
                if (r_cmd.action == ACT_CLOSE) begin
                    hist_we    = 1'b1;
                    hist_waddr = r_bin;
                    hist_wdata = w_hist_inc;
                end else begin
                    n_res_bin = r_hist_q;
                end
                n_state = S_OUT;
            end
            S_CLR: begin
                ring_we    = 1'b1;
                ring_waddr = r_clr_idx[RW-1:0];
                ring_wdata = '0;
                if (r_clr_idx == MW'(RING_DEPTH - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_depth  = r_res_depth;
                    n_out_bin    = r_res_bin;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_idx   <= '0;
            r_depth     <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_depth     <= n_depth;
            r_offset    <= n_offset;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_slot       <= n_slot;
        r_bin        <= n_bin;
        r_res_depth  <= n_res_depth;
        r_res_bin    <= n_res_bin;
        r_res_status <= n_res_status;
        r_out_depth  <= n_out_depth;
        r_out_bin    <= n_out_bin;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= ring_wdata;
        end
        if (ring_re) begin
            r_ring_q <= r_ring[ring_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_waddr] <= hist_wdata;
        end
        if (hist_re) begin
            r_hist_q <= r_hist[hist_raddr];
        end
    end

    assign o_stat.init_busy = r_state == S_INIT;
    assign o_stat.idle      = r_state == S_IDLE;

    assign o_out.valid         = r_out_valid;
    assign o_out.current_depth = r_out_depth;
    assign o_out.bin_count     = r_out_bin;
    assign o_out.status        = r_out_status;
endmodule

// File: hdl/coverage_depth_histogram.sv
// Coverage depth histogram. Items arrive on i_in and go through a four-entry command
// queue to an executing back end that owns two single-port memories: a ring of
// RING_DEPTH read-end counts and a histogram of HIST_BINS 48-bit depth counts. Each
// transaction on i_in yields exactly one result transaction on o_out, in order. The
// back end handles one item at a time, and its memory read-modify-write sets the
// steps: a filtered, rejected or saturated add goes straight to its result, an
// accepted add reads and then writes a ring slot, a close reads the ring, then does a
// dependent histogram read and write, a histogram read reads its bin unless that is
// out of range, and a new reference clears the ring one slot a cycle. After reset
// both memories are cleared, during which i_in.ready stays low. A result waiting in
// the output register stalls the back end only when the next result is due.
module coverage_depth_histogram #(
    parameter int RING_DEPTH = cdh_pkg::RING_DEPTH_DEF,
    parameter int HIST_BINS  = cdh_pkg::HIST_BINS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdh_in_if.sink    i_in,
    cdh_out_if.source o_out
);
    import cdh_pkg::*;

    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    logic       front_push;
    logic       queue_full;
    logic       queue_valid;
    logic       back_pop;
    t_back_stat back_stat;

    cdh_front #(
        .RING_DEPTH (RING_DEPTH),
        .HIST_BINS  (HIST_BINS)
    ) u_front (
        .i_in         (i_in),
        .i_stat       (back_stat),
        .i_queue_full (queue_full),
        .o_push       (front_push),
        .o_cmd        (front_cmd)
    );

    cdh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    cdh_back #(
        .RING_DEPTH (RING_DEPTH),
        .HIST_BINS  (HIST_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_pop   (back_pop),
        .o_stat      (back_stat),
        .o_out       (o_out)
    );

`ifndef SYNTH
    // No transaction is taken while the memories are still being cleared.
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.init_busy |-> !(i_in.valid && i_in.ready))
        else $error("input accepted during memory clear");

    // The back end only pops while it waits for work, and never from an empty queue.
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> (back_stat.idle && queue_valid))
        else $error("queue popped outside idle or when empty");

    a_saturated_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_SATURATED) |-> o_out.current_depth == DEPTH_MAX)
        else $error("saturated status below maximum depth");

    // Only a histogram read returns a count, and it always has ok status.
    a_bin_count_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> o_out.bin_count == '0)
        else $error("bin count on a non-ok result");
`endif
endmodule

// File: test/tb_coverage_depth_histogram.sv
module tb_coverage_depth_histogram;
    import cdh_pkg::*;

    localparam int RING         = RING_DEPTH_DEF;
    localparam int BINS         = HIST_BINS_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int SHOWN_ERRORS = 10;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        t_action           action;
        logic [SPAN_W-1:0] read_span;
        logic              is_mapped;
        logic              is_duplicate;
        logic              failed_qc;
        logic [BIN_W-1:0]  bin_index;
    } t_item;

    typedef struct {
        logic [DEPTH_W-1:0]  depth;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_readout;

    logic i_clk;
    logic i_rst_n;

    cdh_in_if  in_if();
    cdh_out_if out_if();

    coverage_depth_histogram #(
        .RING_DEPTH(RING),
        .HIST_BINS (BINS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Predicted sweep state: pending read ends per ring slot, depth, offset, histogram.
    logic [DEPTH_W-1:0] ends_at [RING];
    logic [DEPTH_W-1:0] cov_depth;
    int                 cur_slot;
    logic [COUNT_W-1:0] depth_hist [BINS];

    t_readout due_readouts [$];
    int       fail_count  = 0;
    bit       idle_on     = 1'b0;
    bit       hold_active = 1'b0;
    int       stall_left  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_sweep();
        for (int i = 0; i < RING; i++) begin
            ends_at[i] = '0;
        end
        cov_depth = '0;
        cur_slot  = 0;
    endfunction

    function automatic t_readout advance_sweep(t_item it);
        t_readout           r;
        logic [DEPTH_W-1:0] ending;
        int                 slot;
        int                 bin;
        r.count  = '0;
        r.status = ST_OK;
        case (it.action)
            ACT_ADD: begin
                if (!it.is_mapped || it.is_duplicate || it.failed_qc) begin
                    r.status = ST_FILTERED;
                end else if (int'(it.read_span) >= RING) begin
                    r.status = ST_SPAN_LONG;
                end else if (cov_depth == DEPTH_MAX) begin
                    r.status = ST_SATURATED;
                end else begin
                    slot          = (cur_slot + int'(it.read_span)) % RING;
                    cov_depth     = cov_depth + 1'b1;
                    ends_at[slot] = ends_at[slot] + 1'b1;
                end
            end
            ACT_CLOSE: begin
                ending            = ends_at[cur_slot];
                cov_depth         = (ending > cov_depth) ? '0 : cov_depth - ending;
                ends_at[cur_slot] = '0;
                bin               = (cov_depth >= BINS - 1) ? BINS - 1 : int'(cov_depth);
                if (depth_hist[bin] != COUNT_MAX) begin
                    depth_hist[bin] = depth_hist[bin] + 1'b1;
                end
                cur_slot = (cur_slot + 1) % RING;
            end
            ACT_NEWREF: begin
                clear_sweep();
            end
            default: begin
                if (int'(it.bin_index) < BINS) begin
                    r.count = depth_hist[it.bin_index];
                end
            end
        endcase
        r.depth = cov_depth;
        return r;
    endfunction

    function automatic t_item make_item(t_action act, int span, int bin, bit clean);
        t_item it;
        it.action       = act;
        it.read_span    = SPAN_W'(span);
        it.bin_index    = BIN_W'(bin);
        it.is_mapped    = 1'($urandom_range(0, 1));
        it.is_duplicate = 1'($urandom_range(0, 1));
        it.failed_qc    = 1'($urandom_range(0, 1));
        if (clean) begin
            it.is_mapped    = 1'b1;
            it.is_duplicate = 1'b0;
            it.failed_qc    = 1'b0;
        end
        return it;
    endfunction

    // Short and full-length reads dominate; those are where the ring slot arithmetic wraps.
    function automatic int rand_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $urandom_range(0, 8);
        end else if (pick < 70) begin
            return $urandom_range(0, RING - 1);
        end else if (pick < 85) begin
            return RING - 1;
        end
        return 0;
    endfunction

    function automatic t_item rand_sweep_item();
        int pick;
        int bin;
        pick = $urandom_range(0, 99);
        bin  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 40) : $urandom_range(0, BINS - 1);
        if (pick < 50) begin
            return make_item(ACT_ADD, rand_span(), bin, 1'b1);
        end else if (pick < 85) begin
            return make_item(ACT_CLOSE, rand_span(), bin, 1'b0);
        end
        return make_item(ACT_READBIN, rand_span(), bin, 1'b0);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic issue_item(input t_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= it.action;
        in_if.read_span    <= it.read_span;
        in_if.is_mapped    <= it.is_mapped;
        in_if.is_duplicate <= it.is_duplicate;
        in_if.failed_qc    <= it.failed_qc;
        in_if.bin_index    <= it.bin_index;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        due_readouts.push_back(advance_sweep(it));
        @(negedge i_clk);
    endtask

    task automatic stop_items();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        t_item it;
        idle_on = 1'b0;
        issue_item(make_item(ACT_READBIN, 0, 0, 1'b0));
        it = make_item(ACT_ADD, 5, 0, 1'b1);
        it.is_mapped = 1'b0;
        issue_item(it);
        it = make_item(ACT_ADD, 5, 0, 1'b1);
        it.is_duplicate = 1'b1;
        issue_item(it);
        it = make_item(ACT_ADD, 5, 0, 1'b1);
        it.failed_qc = 1'b1;
        issue_item(it);
        it = make_item(ACT_ADD, RING - 1, BINS - 1, 1'b1);
        it.is_mapped    = 1'b0;
        it.is_duplicate = 1'b1;
        it.failed_qc    = 1'b1;
        issue_item(it);
        // A zero-span read is gone again before the close bins the depth.
        issue_item(make_item(ACT_ADD, 0, 0, 1'b1));
        issue_item(make_item(ACT_CLOSE, 0, 0, 1'b0));
        issue_item(make_item(ACT_ADD, RING - 1, BINS - 1, 1'b1));
        issue_item(make_item(ACT_ADD, 1, 0, 1'b1));
        issue_item(make_item(ACT_ADD, 2, 0, 1'b1));
        issue_item(make_item(ACT_CLOSE, 0, 0, 1'b0));
        issue_item(make_item(ACT_CLOSE, 0, 0, 1'b0));
        issue_item(make_item(ACT_CLOSE, 0, 0, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, 0, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, 3, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, BINS - 1, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, BINS - 2, 1'b0));
        issue_item(make_item(ACT_NEWREF, RING - 1, BINS - 1, 1'b0));
        issue_item(make_item(ACT_CLOSE, RING - 1, BINS - 1, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, 0, 1'b0));
        issue_item(make_item(ACT_ADD, RING - 1, BINS - 1, 1'b1));
        issue_item(make_item(ACT_READBIN, 0, 10'h2AA, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, 10'h155, 1'b0));
    endtask

    // Over a thousand live reads push the depth into the last bin, and the closes
    // that follow keep counting there.
    task automatic test_deep_pileup();
        int span;
        int bin;
        issue_item(make_item(ACT_NEWREF, 0, 0, 1'b0));
        for (int i = 0; i < RING + 8; i++) begin
            if (i % 128 == 0) begin
                idle_on = 1'($urandom_range(0, 1));
            end
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(RING - 40, RING - 1) : RING - 1;
            issue_item(make_item(ACT_ADD, span, $urandom_range(0, BINS - 1), 1'b1));
            if (i % 97 == 0) begin
                issue_item(make_item(ACT_READBIN, 0, $urandom_range(0, BINS - 1), 1'b0));
            end
        end
        for (int i = 0; i < 64; i++) begin
            issue_item(make_item(ACT_CLOSE, $urandom_range(0, RING - 1), 0, 1'b0));
            if (i % 61 == 0) begin
                bin = BINS - 1 - $urandom_range(0, 1);
                issue_item(make_item(ACT_READBIN, 0, bin, 1'b0));
            end
        end
        issue_item(make_item(ACT_READBIN, 0, BINS - 1, 1'b0));
        issue_item(make_item(ACT_READBIN, 0, BINS - 2, 1'b0));
    endtask

    // The receiver holds off long enough for the command queue and output register
    // to fill, so the block has to stall its input while the sender keeps offering.
    task automatic test_backpressure();
        idle_on = 1'b0;
        fork
            begin
                @(posedge i_clk);
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end
        join_none
        for (int i = 0; i < 24; i++) begin
            issue_item(rand_sweep_item());
        end
    endtask

    task automatic test_random();
        int pick;
        int burst;
        for (int n = 0; n < 32; n++) begin
            if (n % 16 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                issue_item(make_item(ACT_NEWREF, $urandom_range(0, RING - 1),
                                     $urandom_range(0, BINS - 1), 1'b0));
            end else if (pick < 13) begin
                // Noise: mostly reads that get filtered out.
                issue_item(make_item(ACT_ADD, $urandom_range(0, RING - 1),
                                     $urandom_range(0, BINS - 1), 1'b0));
            end else if (pick < 18) begin
                issue_item(make_item(ACT_READBIN, $urandom_range(0, RING - 1),
                                     $urandom_range(0, BINS - 1), 1'b0));
            end else begin
                burst = $urandom_range(2, 10);
                repeat (burst) issue_item(rand_sweep_item());
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_readout want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_readouts.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS) begin
                    $display("unexpected result: depth=%0d count=%0d status=%0d",
                             out_if.current_depth, out_if.bin_count, out_if.status);
                end
            end else begin
                want = due_readouts.pop_front();
                if (out_if.current_depth !== want.depth || out_if.bin_count !== want.count
                        || out_if.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS) begin
                        $display("mismatch: depth exp %0d got %0d, count exp %0d got %0d, %s%0d got %0d",
                                 want.depth, out_if.current_depth, want.count,
                                 out_if.bin_count, "status exp ", want.status, out_if.status);
                    end
                end
            end
            stall_left = idle_on ? $urandom_range(0, 9) : 0;
        end
    end

    always @(negedge i_clk) begin
        if (hold_active || stall_left > 0) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
        if (!hold_active && stall_left > 0) begin
            stall_left = stall_left - 1;
        end
    end

    initial begin
        #5_000_000;
        $display("tb_coverage_depth_histogram: FAIL");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.action       = ACT_ADD;
        in_if.read_span    = '0;
        in_if.is_mapped    = 1'b0;
        in_if.is_duplicate = 1'b0;
        in_if.failed_qc    = 1'b0;
        in_if.bin_index    = '0;
        out_if.ready       = 1'b0;
        for (int i = 0; i < BINS; i++) begin
            depth_hist[i] = '0;
        end
        clear_sweep();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_deep_pileup();
        test_backpressure();
        test_random();
        stop_items();

        while (due_readouts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_coverage_depth_histogram: PASS");
        end else begin
            $display("tb_coverage_depth_histogram: FAIL");
        end
        $finish;
    end

endmodule
